>>> rtl/hmm_sequence_sampler_defines.svh
// Assertion macros shared by the sampler RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef HMM_SEQUENCE_SAMPLER_DEFINES_SVH
`define HMM_SEQUENCE_SAMPLER_DEFINES_SVH

// Same-cycle implication under synchronous active-low reset
`define HSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under synchronous active-low reset
`define HSS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/hss_pkg.sv
// Shared types, constants and helpers for the HMM sequence sampler.
// No dependencies; used by hss_walk and hmm_sequence_sampler.
`timescale 1ns / 1ps

package hss_pkg;

    localparam int MAX_STATES  = 16;
    localparam int MAX_SYMBOLS = 16;
    localparam int PROB_BITS   = 16;
    localparam int IDX_W       = 4;
    localparam int CNT_W       = 5;
    localparam int ACC_W       = PROB_BITS + IDX_W;
    localparam int TRANS_DEPTH = MAX_STATES * MAX_STATES;
    localparam int EMIS_DEPTH  = MAX_STATES * MAX_SYMBOLS;

    typedef enum logic [2:0] {
        CMD_LOAD_INIT  = 3'd0,
        CMD_LOAD_TRANS = 3'd1,
        CMD_LOAD_EMIS  = 3'd2,
        CMD_START      = 3'd3,
        CMD_EMIT       = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } t_state;

    typedef enum logic {
        REG_NUM_STATES  = 1'b0,
        REG_NUM_SYMBOLS = 1'b1
    } t_reg;

    typedef struct packed {
        logic [2:0]           cmd;
        logic [IDX_W-1:0]     row_index;
        logic [IDX_W-1:0]     col_index;
        logic [PROB_BITS-1:0] prob_value;
        logic [PROB_BITS-1:0] rand_first;
        logic [PROB_BITS-1:0] rand_second;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] symbol;
        logic [IDX_W-1:0] next_state;
    } t_out_item;

    // Request from the sequencer into a table walker
    typedef struct packed {
        logic                 go;
        logic [CNT_W-1:0]     size;
        logic [PROB_BITS-1:0] rnd;
    } t_walk_req;

    // Status from a table walker back to the sequencer
    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic             done;
        logic [IDX_W-1:0] index;
    } t_walk_rsp;

    // Map a count register onto 1..max
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                      input logic [CNT_W-1:0] maxv);
        logic [CNT_W-1:0] res;
        begin
            if (v == '0) begin
                res = CNT_W'(1);
            end else if (v > maxv) begin
                res = maxv;
            end else begin
                res = v;
            end
            return res;
        end
    endfunction

endpackage

>>> rtl/hss_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the probability tables of the sampler.
`timescale 1ns / 1ps

module hss_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/hss_walk.sv
// Table walker: streams one row out of a RAM and finds the cumulative-sum hit.
// Depends on hss_pkg and the assertion macros in hmm_sequence_sampler_defines.svh.
`timescale 1ns / 1ps
`include "hmm_sequence_sampler_defines.svh"

module hss_walk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hss_pkg::t_walk_req             i_req,
    input  logic [hss_pkg::PROB_BITS-1:0]  i_rd_data,
    output hss_pkg::t_walk_rsp             o_rsp
);

    logic                          r_issuing, n_issuing;
    logic [hss_pkg::IDX_W-1:0]     r_addr, n_addr;
    logic                          r_dvalid, n_dvalid;
    logic [hss_pkg::IDX_W-1:0]     r_didx, n_didx;
    logic [hss_pkg::ACC_W-1:0]     r_acc, n_acc;
    logic                          r_done, n_done;
    logic [hss_pkg::IDX_W-1:0]     r_index, n_index;
    logic [hss_pkg::PROB_BITS-1:0] r_rnd, n_rnd;
    logic [hss_pkg::IDX_W-1:0]     r_last, n_last;
    logic [hss_pkg::ACC_W-1:0]     sum;
    logic                          hit;

    // Running sum and first-hit test on the entry that just came back
    assign sum = r_acc + hss_pkg::ACC_W'(i_rd_data);
    assign hit = r_dvalid && !r_done &&
                 ((hss_pkg::ACC_W'(r_rnd) <= sum) || (r_didx == r_last));

    // Issue one address a cycle, accumulate one entry a cycle
    always_comb begin
        n_issuing = r_issuing;
        n_addr    = r_addr;
        n_dvalid  = 1'b0;
        n_didx    = r_didx;
        n_acc     = r_acc;
        n_done    = r_done;
        n_index   = r_index;
        n_rnd     = r_rnd;
        n_last    = r_last;
        if (i_req.go) begin
            n_issuing = 1'b1;
            n_addr    = '0;
            n_acc     = '0;
            n_done    = 1'b0;
            n_rnd     = i_req.rnd;
            n_last    = hss_pkg::IDX_W'(i_req.size - hss_pkg::CNT_W'(1));
        end else begin
            if (r_issuing) begin
                n_dvalid = 1'b1;
                n_didx   = r_addr;
                n_addr   = r_addr + hss_pkg::IDX_W'(1);
                if (r_addr == r_last) begin
                    n_issuing = 1'b0;
                end
            end
            if (r_dvalid && !r_done) begin
                n_acc = sum;
                if (hit) begin
                    n_done    = 1'b1;
                    n_index   = r_didx;
                    n_issuing = 1'b0;
                    n_dvalid  = 1'b0;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issuing <= 1'b0;
            r_dvalid  <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_issuing <= n_issuing;
            r_dvalid  <= n_dvalid;
            r_done    <= n_done;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_didx  <= n_didx;
        r_acc   <= n_acc;
        r_index <= n_index;
        r_rnd   <= n_rnd;
        r_last  <= n_last;
    end

    assign o_rsp.rd_addr = r_addr;
    assign o_rsp.done    = r_done;
    assign o_rsp.index   = r_index;

    `HSS_ASSERT_NXT(a_last_entry_ends, (r_dvalid && !r_done && r_didx == r_last && !i_req.go), r_done, "walker passed the last entry without finishing")
    `HSS_ASSERT_NOW(a_index_in_row, r_done, (r_index <= r_last), "walker result beyond row size")
    `HSS_ASSERT_NOW(a_done_from_data, $rose(r_done), $past(r_dvalid), "walker finished without read data")

endmodule

>>> rtl/hmm_sequence_sampler.sv
// HMM sequence sampler; depends on hss_pkg, hss_ram, hss_walk and hmm_sequence_sampler_defines.svh.
// A load request writes its table entry when it is accepted; a start or an emit raises its
// result once its walkers have finished, as both rows stream from their own RAMs at one
// entry per cycle; a walk ends at its first hit.
// One draw is in flight at a time: the next request is taken only after the result has been
// registered, and a stalled earlier result can delay it. Reset: counts 16, state 0.
`timescale 1ns / 1ps
`include "hmm_sequence_sampler_defines.svh"

module hmm_sequence_sampler (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  hss_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output hss_pkg::t_out_item   o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    hss_pkg::t_state                r_state, n_state;
    logic [hss_pkg::CNT_W-1:0]      r_num_states;
    logic [hss_pkg::CNT_W-1:0]      r_num_symbols;
    logic [hss_pkg::IDX_W-1:0]      r_cur_state;
    logic                           r_is_emit;
    logic                           r_out_valid;
    hss_pkg::t_out_item             r_out_data;

    logic                           in_acc;
    logic                           cfg_wr;
    hss_pkg::t_reg                  cfg_sel;
    logic                           is_start;
    logic                           is_emit;
    logic                           all_done;
    logic                           finish;
    logic [hss_pkg::CNT_W-1:0]      ns_clamp;
    logic [hss_pkg::CNT_W-1:0]      nm_clamp;

    logic                           we_init, we_trans, we_emis;
    logic [hss_pkg::PROB_BITS-1:0]  init_rdata, trans_rdata, emis_rdata, a_rdata;

    hss_pkg::t_walk_req             a_req, b_req;
    hss_pkg::t_walk_rsp             a_rsp, b_rsp;

    // Handshakes and decode
    assign in_acc   = i_in_valid && !o_in_stall;
    assign is_start = (i_in_data.cmd == hss_pkg::CMD_START);
    assign is_emit  = (i_in_data.cmd == hss_pkg::CMD_EMIT);
    assign ns_clamp = hss_pkg::clamp_count(r_num_states, hss_pkg::CNT_W'(hss_pkg::MAX_STATES));
    assign nm_clamp = hss_pkg::clamp_count(r_num_symbols, hss_pkg::CNT_W'(hss_pkg::MAX_SYMBOLS));
    assign all_done = a_rsp.done && (!r_is_emit || b_rsp.done);
    assign finish   = (r_state == hss_pkg::ST_HOLD) && (!r_out_valid || !i_out_stall);

    // Configuration port
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = hss_pkg::t_reg'(paddr[2]);
    assign pready  = 1'b1;

    always_comb begin
        case (cfg_sel)
            hss_pkg::REG_NUM_STATES:  prdata = 32'(r_num_states);
            hss_pkg::REG_NUM_SYMBOLS: prdata = 32'(r_num_symbols);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_states  <= hss_pkg::CNT_W'(hss_pkg::MAX_STATES);
            r_num_symbols <= hss_pkg::CNT_W'(hss_pkg::MAX_SYMBOLS);
        end else if (cfg_wr) begin
            case (cfg_sel)
                hss_pkg::REG_NUM_STATES:  r_num_states  <= pwdata[hss_pkg::CNT_W-1:0];
                hss_pkg::REG_NUM_SYMBOLS: r_num_symbols <= pwdata[hss_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hss_pkg::ST_IDLE: begin
                if (in_acc && (is_start || is_emit)) begin
                    n_state = hss_pkg::ST_RUN;
                end
            end
            hss_pkg::ST_RUN: begin
                if (all_done) begin
                    n_state = hss_pkg::ST_HOLD;
                end
            end
            hss_pkg::ST_HOLD: begin
                if (finish) begin
                    n_state = hss_pkg::ST_IDLE;
                end
            end
            default: n_state = hss_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: stall, table writes, walker launches
    always_comb begin
        o_in_stall = (r_state != hss_pkg::ST_IDLE);
        we_init    = 1'b0;
        we_trans   = 1'b0;
        we_emis    = 1'b0;
        a_req.go   = 1'b0;
        b_req.go   = 1'b0;
        if (in_acc) begin
            case (i_in_data.cmd)
                hss_pkg::CMD_LOAD_INIT:  we_init  = 1'b1;
                hss_pkg::CMD_LOAD_TRANS: we_trans = 1'b1;
                hss_pkg::CMD_LOAD_EMIS:  we_emis  = 1'b1;
                hss_pkg::CMD_START:      a_req.go = 1'b1;
                hss_pkg::CMD_EMIT: begin
                    a_req.go = 1'b1;
                    b_req.go = 1'b1;
                end
                default: ;
            endcase
        end
        a_req.size = is_emit ? nm_clamp : ns_clamp;
        a_req.rnd  = i_in_data.rand_first;
        b_req.size = ns_clamp;
        b_req.rnd  = i_in_data.rand_second;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hss_pkg::ST_IDLE;
            r_cur_state <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (finish) begin
                r_cur_state <= r_is_emit ? b_rsp.index : a_rsp.index;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the request kind and the result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_is_emit <= is_emit;
        end
        if (finish) begin
            r_out_data.symbol     <= r_is_emit ? a_rsp.index : '0;
            r_out_data.next_state <= r_is_emit ? b_rsp.index : a_rsp.index;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Probability tables
    hss_ram #(
        .DEPTH (hss_pkg::MAX_STATES),
        .WIDTH (hss_pkg::PROB_BITS)
    ) u_init_ram (
        .i_clk   (i_clk),
        .i_we    (we_init),
        .i_waddr (i_in_data.col_index),
        .i_wdata (i_in_data.prob_value),
        .i_raddr (a_rsp.rd_addr),
        .o_rdata (init_rdata)
    );

    hss_ram #(
        .DEPTH (hss_pkg::TRANS_DEPTH),
        .WIDTH (hss_pkg::PROB_BITS)
    ) u_trans_ram (
        .i_clk   (i_clk),
        .i_we    (we_trans),
        .i_waddr ({i_in_data.row_index, i_in_data.col_index}),
        .i_wdata (i_in_data.prob_value),
        .i_raddr ({r_cur_state, b_rsp.rd_addr}),
        .o_rdata (trans_rdata)
    );

    hss_ram #(
        .DEPTH (hss_pkg::EMIS_DEPTH),
        .WIDTH (hss_pkg::PROB_BITS)
    ) u_emis_ram (
        .i_clk   (i_clk),
        .i_we    (we_emis),
        .i_waddr ({i_in_data.row_index, i_in_data.col_index}),
        .i_wdata (i_in_data.prob_value),
        .i_raddr ({r_cur_state, a_rsp.rd_addr}),
        .o_rdata (emis_rdata)
    );

    // Walker A draws the start state or the symbol; walker B draws the next state
    assign a_rdata = r_is_emit ? emis_rdata : init_rdata;

    hss_walk u_walk_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (a_req),
        .i_rd_data (a_rdata),
        .o_rsp     (a_rsp)
    );

    hss_walk u_walk_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (b_req),
        .i_rd_data (trans_rdata),
        .o_rsp     (b_rsp)
    );

    `HSS_ASSERT_NXT(a_run_to_hold, (r_state == hss_pkg::ST_RUN && all_done), (r_state == hss_pkg::ST_HOLD), "sequencer missed walk completion")
    `HSS_ASSERT_NXT(a_state_only_at_finish, (!finish), $stable(r_cur_state), "current state changed outside result delivery")
    `HSS_ASSERT_NOW(a_result_from_hold, $rose(r_out_valid), ($past(r_state) == hss_pkg::ST_HOLD), "result raised without a finished draw")

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the HMM sequence sampler: loads, start and emit requests
// are predicted in-bench and each result is compared against the oldest prediction.
// Depends on hss_pkg and the hmm_sequence_sampler RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_PAD   = 40;
    localparam int PHASE_ITEMS = 35;
    localparam int FIRST_ITEMS = 100;
    localparam int NUM_PHASES  = 8;
    localparam logic [hss_pkg::PROB_BITS-1:0] SMALL_PROB_MAX = 16'd4095;
    localparam logic [hss_pkg::PROB_BITS-1:0] PROB_ONE       = 16'hFFFF;
    localparam logic [2:0] ADDR_STATES  = 3'(4 * int'(hss_pkg::REG_NUM_STATES));
    localparam logic [2:0] ADDR_SYMBOLS = 3'(4 * int'(hss_pkg::REG_NUM_SYMBOLS));

    typedef logic [hss_pkg::PROB_BITS-1:0] t_row [hss_pkg::MAX_STATES];
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY
    } t_stall_mode;

    // DUT connections, all inputs known from time zero
    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               in_valid  = 1'b0;
    hss_pkg::t_in_item  in_data   = '0;
    logic               out_stall = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [2:0]         paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    hss_pkg::t_out_item o_out_data;
    logic [31:0]        prdata;
    logic               pready;

    // Predictor state
    t_row                          init_tab;
    t_row                          trans_tab [hss_pkg::MAX_STATES];
    t_row                          emis_tab [hss_pkg::MAX_STATES];
    logic [hss_pkg::IDX_W-1:0]     cur_state   = '0;
    logic [hss_pkg::CNT_W-1:0]     cfg_states  = hss_pkg::CNT_W'(16);
    logic [hss_pkg::CNT_W-1:0]     cfg_symbols = hss_pkg::CNT_W'(16);

    hss_pkg::t_in_item  req_queue [$];
    hss_pkg::t_out_item obs_expected [$];
    hss_pkg::t_out_item want;
    int                 errors      = 0;
    int                 cycle_count = 0;
    int                 burst_left  = 1;
    int                 gap_left    = 0;
    t_stall_mode        stall_mode  = STALL_NONE;
    int                 stall_span  = 0;

    hmm_sequence_sampler i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Map a count register onto the range in use
    function automatic int count_in_use(input logic [hss_pkg::CNT_W-1:0] v, input int maxv);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > maxv) begin
            return maxv;
        end
        return int'(v);
    endfunction

    // Walk a row's cumulative sum; take the first index reaching r, else the last in use
    function automatic logic [hss_pkg::IDX_W-1:0] draw_pick(input t_row row, input int size,
                                                            input logic [hss_pkg::PROB_BITS-1:0] r);
        logic [31:0] acc;
        int          i;
        acc = '0;
        for (i = 0; i < size; i++) begin
            acc = acc + 32'(row[i]);
            if (32'(r) <= acc) begin
                return hss_pkg::IDX_W'(i);
            end
        end
        return hss_pkg::IDX_W'(size - 1);
    endfunction

    // Apply one accepted request to the model and queue the observation it causes
    task automatic predict_request(input hss_pkg::t_in_item rq);
        hss_pkg::t_out_item        res;
        int                        ns;
        int                        nm;
        logic [hss_pkg::IDX_W-1:0] cs;
        ns = count_in_use(cfg_states, hss_pkg::MAX_STATES);
        nm = count_in_use(cfg_symbols, hss_pkg::MAX_SYMBOLS);
        cs = cur_state;
        case (rq.cmd)
            hss_pkg::CMD_LOAD_INIT: begin
                init_tab[rq.col_index] = rq.prob_value;
            end
            hss_pkg::CMD_LOAD_TRANS: begin
                trans_tab[rq.row_index][rq.col_index] = rq.prob_value;
            end
            hss_pkg::CMD_LOAD_EMIS: begin
                emis_tab[rq.row_index][rq.col_index] = rq.prob_value;
            end
            hss_pkg::CMD_START: begin
                cur_state = draw_pick(init_tab, ns, rq.rand_first);
                res.symbol = '0;
                res.next_state = cur_state;
                obs_expected.push_back(res);
            end
            hss_pkg::CMD_EMIT: begin
                res.symbol = draw_pick(emis_tab[cs], nm, rq.rand_first);
                cur_state = draw_pick(trans_tab[cs], ns, rq.rand_second);
                res.next_state = cur_state;
                obs_expected.push_back(res);
            end
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic push_req(input logic [2:0] cmd, input int row, input int col,
                            input logic [hss_pkg::PROB_BITS-1:0] prob,
                            input logic [hss_pkg::PROB_BITS-1:0] r1,
                            input logic [hss_pkg::PROB_BITS-1:0] r2);
        hss_pkg::t_in_item rq;
        rq.cmd = cmd;
        rq.row_index = hss_pkg::IDX_W'(row);
        rq.col_index = hss_pkg::IDX_W'(col);
        rq.prob_value = prob;
        rq.rand_first = r1;
        rq.rand_second = r2;
        req_queue.push_back(rq);
    endtask

    function automatic logic [hss_pkg::PROB_BITS-1:0] rand_prob();
        case ($urandom_range(7))
            0: return '0;
            1: return PROB_ONE;
            2, 3: return hss_pkg::PROB_BITS'($urandom_range(PROB_ONE));
            default: return hss_pkg::PROB_BITS'($urandom_range(SMALL_PROB_MAX));
        endcase
    endfunction

    // Mostly emits and starts over a live model, with reloads and a little noise
    function automatic hss_pkg::t_in_item rand_request();
        hss_pkg::t_in_item rq;
        int                pick;
        rq.row_index = hss_pkg::IDX_W'($urandom_range(15));
        rq.col_index = hss_pkg::IDX_W'($urandom_range(15));
        rq.prob_value = rand_prob();
        rq.rand_first = hss_pkg::PROB_BITS'($urandom_range(PROB_ONE));
        rq.rand_second = hss_pkg::PROB_BITS'($urandom_range(PROB_ONE));
        pick = $urandom_range(99);
        if (pick < 55) begin
            rq.cmd = hss_pkg::CMD_EMIT;
        end else if (pick < 65) begin
            rq.cmd = hss_pkg::CMD_START;
        end else if (pick < 75) begin
            rq.cmd = hss_pkg::CMD_LOAD_INIT;
        end else if (pick < 85) begin
            rq.cmd = hss_pkg::CMD_LOAD_TRANS;
        end else if (pick < 95) begin
            rq.cmd = hss_pkg::CMD_LOAD_EMIS;
        end else begin
            rq.cmd = 3'(hss_pkg::CMD_EMIT) + 3'($urandom_range(3, 1));
        end
        return rq;
    endfunction

    // Register write with a setup phase then an access phase; the model copy follows once the access completes
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_STATES) begin
            cfg_states = value[hss_pkg::CNT_W-1:0];
        end else begin
            cfg_symbols = value[hss_pkg::CNT_W-1:0];
        end
    endtask

    task automatic set_counts(input logic [31:0] states, input logic [31:0] symbols);
        reg_write(ADDR_STATES, states);
        reg_write(ADDR_SYMBOLS, symbols);
    endtask

    // Hold until every request is out and every observation is back, then let the block settle
    task automatic drain();
        do @(negedge i_clk);
        while (req_queue.size() != 0 || in_valid || obs_expected.size() != 0);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic push_random(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            req_queue.push_back(rand_request());
        end
    endtask

    // Request driver: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                predict_request(in_data);
            end
            if (!in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (req_queue.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data <= req_queue.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(16, 1);
                        gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result stall: switch between no, light and heavy back-pressure
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(2));
            stall_span <= $urandom_range(200, 20);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(2) == 0);
            default:     out_stall <= ($urandom_range(3) != 0);
        endcase
    end

    // Result monitor: compare each accepted observation with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (obs_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected result sym=%0d state=%0d",
                                          o_out_data.symbol, o_out_data.next_state));
            end else begin
                want = obs_expected.pop_front();
                if (o_out_data.symbol != want.symbol) begin
                    report_mismatch($sformatf("symbol got %0d want %0d",
                                              o_out_data.symbol, want.symbol));
                end
                if (o_out_data.next_state != want.next_state) begin
                    report_mismatch($sformatf("next_state got %0d want %0d",
                                              o_out_data.next_state, want.next_state));
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int p;
        int r;
        int c;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_counts(32'd16, 32'd16);

        // Write every table entry before any draw; small values keep rows below 1.0
        for (c = 0; c < hss_pkg::MAX_STATES; c++) begin
            push_req(hss_pkg::CMD_LOAD_INIT, $urandom_range(15), c,
                     hss_pkg::PROB_BITS'($urandom_range(SMALL_PROB_MAX)), '0, '0);
        end
        for (r = 0; r < hss_pkg::MAX_STATES; r++) begin
            for (c = 0; c < hss_pkg::MAX_STATES; c++) begin
                push_req(hss_pkg::CMD_LOAD_TRANS, r, c,
                         hss_pkg::PROB_BITS'($urandom_range(SMALL_PROB_MAX)), '0, '0);
                push_req(hss_pkg::CMD_LOAD_EMIS, r, c,
                         hss_pkg::PROB_BITS'($urandom_range(SMALL_PROB_MAX)), '0, '0);
            end
        end

        // Directed: row index ignored on initial loads, extreme values and draws
        push_req(hss_pkg::CMD_LOAD_INIT, 15, 0, '0, PROB_ONE, PROB_ONE);
        push_req(hss_pkg::CMD_LOAD_INIT, 9, 3, PROB_ONE, '0, '0);
        push_req(hss_pkg::CMD_START, 0, 0, '0, '0, '0);
        push_req(hss_pkg::CMD_START, 15, 15, PROB_ONE, PROB_ONE, PROB_ONE);
        push_req(hss_pkg::CMD_LOAD_TRANS, 0, 15, PROB_ONE, '0, '0);
        push_req(hss_pkg::CMD_LOAD_EMIS, 15, 0, '0, PROB_ONE, PROB_ONE);
        push_req(hss_pkg::CMD_LOAD_EMIS, 0, 15, PROB_ONE, '0, '0);
        push_req(hss_pkg::CMD_EMIT, 0, 0, '0, '0, '0);
        push_req(hss_pkg::CMD_EMIT, 15, 15, PROB_ONE, PROB_ONE, PROB_ONE);
        push_req(hss_pkg::CMD_EMIT, 0, 15, '0, '0, PROB_ONE);
        push_req(hss_pkg::CMD_EMIT, 15, 0, PROB_ONE, PROB_ONE, '0);
        push_req(3'(hss_pkg::CMD_EMIT) + 3'd1, 15, 15, PROB_ONE, PROB_ONE, PROB_ONE);
        push_req(3'(hss_pkg::CMD_EMIT) + 3'd2, 0, 0, '0, '0, '0);
        push_req(3'(hss_pkg::CMD_EMIT) + 3'd3, 15, 15, PROB_ONE, PROB_ONE, PROB_ONE);
        push_req(hss_pkg::CMD_START, 0, 0, '0,
                 hss_pkg::PROB_BITS'($urandom_range(PROB_ONE)), '0);
        push_random(FIRST_ITEMS);

        // Park the chain in the last state so the next phase starts outside the range in use
        for (c = 0; c < hss_pkg::MAX_STATES; c++) begin
            push_req(hss_pkg::CMD_LOAD_INIT, 0, c,
                     hss_pkg::PROB_BITS'($urandom_range(SMALL_PROB_MAX)), '0, '0);
        end
        push_req(hss_pkg::CMD_START, 0, 0, '0, PROB_ONE, '0);
        drain();

        // Later phases: sweep the counts, extremes and out-of-range values among them
        for (p = 1; p < NUM_PHASES; p++) begin
            case (p)
                1: set_counts(32'd1, 32'd1);
                2: set_counts(32'd0, 32'd0);
                3: set_counts(32'hFFFF_FFFF, 32'd17);
                4: set_counts($urandom_range(15, 2), $urandom_range(15, 2));
                5: set_counts(32'd16, 32'd3);
                6: set_counts(32'd2, 32'd16);
                default: set_counts($urandom, $urandom_range(31));
            endcase
            if (p == 1) begin
                push_req(hss_pkg::CMD_EMIT, 0, 0, '0,
                         hss_pkg::PROB_BITS'($urandom_range(PROB_ONE)),
                         hss_pkg::PROB_BITS'($urandom_range(PROB_ONE)));
            end else begin
                push_req(hss_pkg::CMD_START, 0, 0, '0,
                         hss_pkg::PROB_BITS'($urandom_range(PROB_ONE)), '0);
            end
            push_random(PHASE_ITEMS);
            drain();
        end

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
